[rtl/core/cmrr_pkg.sv]
`timescale 1ns / 1ps
package cmrr_pkg;
  localparam int MAX_CITIES = 16;
  localparam int IDX_W = $clog2(MAX_CITIES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int ENTRY_W = 17;
  localparam int TOTAL_W = 21;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_REDUCE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [0:0] REG_CITIES = 1'd0;
endpackage

[rtl/core/cost_matrix_row_column_reduction.sv]
`timescale 1ns / 1ps
// Cost matrix row and column reduction.
// Input channel (in_valid/in_ready) carries one command per transfer: mode 0
// writes one matrix entry, mode 2 reads one back, mode 1 optionally masks a
// branch and then reduces the active N-by-N square. Mode 3 is dropped.
// Output channel (out_valid/out_ready) carries one result for modes 1 and 2.
// Writes may be sent every cycle while the sequencer is idle. A read result is
// registered in rdata_r and then in the output register, where it is valid.
// A reduction is run by a sequencer over the memory port: masking writes the
// from row, the to column and the return entry, then each of the 2N lines takes
// a minimum pass of N reads and, when its minimum is nonzero and finite, a
// subtract pass of N reads and up to N writes (infinite entries are kept).
// A finished result sits in the output register; a further write may be
// accepted while it waits, but a read or reduction waits until the result
// is taken. The matrix has no reset and must be written before it is read.
// Reset sets cities_in_use to 16 and empties the output register.
// The APB-style cfg_ port holds cities_in_use at address 0.
module cost_matrix_row_column_reduction
  import cmrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [15:0] in_entry_value,
  input  logic        in_entry_inf,
  input  logic        in_branch,
  input  logic [3:0]  in_from_city,
  input  logic [3:0]  in_to_city,
  input  logic [3:0]  in_start_city,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value_out,
  output logic        out_value_is_inf,
  output logic [20:0] out_reduction_total,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_BRREAD, S_MROW, S_MCOL, S_MRET,
    S_MIN, S_MINLAST, S_SUB, S_SUBW, S_DONE
  } state_t;

  state_t state_r;
  logic [4:0] cities_r;
  logic [ENTRY_W-1:0] mem [MAX_CITIES*MAX_CITIES];
  logic [ENTRY_W-1:0] rdata_r;
  logic [ADDR_W-1:0] maddr;
  logic mre, mwe;
  logic [ENTRY_W-1:0] mwdata;

  logic [IDX_W:0] n;
  logic [IDX_W-1:0] fc_r, tc_r, sc_r, line_r, k_r;
  logic by_col_r;
  logic fc_ok_r, tc_ok_r, sc_ok_r;
  logic [ENTRY_W-1:0] least_r;
  logic [TOTAL_W-1:0] total_r;
  logic [15:0] ov_r;
  logic oinf_r;
  logic ovalid_r;
  logic last_k, last_line;
  logic [IDX_W-1:0] k_nxt_i;
  logic [ADDR_W-1:0] line_addr;
  logic [TOTAL_W:0] sum;

  assign n = (cities_r > 5'(MAX_CITIES)) ? (IDX_W+1)'(MAX_CITIES) : cities_r[IDX_W:0];
  assign last_k = ({1'b0, k_r} == n - 1'b1);
  assign last_line = ({1'b0, line_r} == n - 1'b1);
  assign k_nxt_i = k_r + 1'b1;
  assign line_addr = by_col_r ? {k_r, line_r} : {line_r, k_r};
  assign sum = {1'b0, total_r} + {{(TOTAL_W+1-ENTRY_W){1'b0}}, least_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {27'd0, cities_r};
  assign in_ready = (state_r == S_IDLE) && (!ovalid_r || in_mode == MODE_WRITE
                    || in_mode == MODE_NONE);
  assign out_valid = ovalid_r;

  always_comb begin
    maddr = '0;
    mre = 1'b0;
    mwe = 1'b0;
    mwdata = {1'b1, 16'd0};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_mode == MODE_WRITE) begin
            maddr = {in_row, in_col};
            mwe = 1'b1;
            mwdata = in_entry_inf ? {1'b1, 16'd0} : {1'b0, in_entry_value};
          end else begin
            maddr = (in_mode == MODE_READ) ? {in_row, in_col} : {in_from_city, in_to_city};
            mre = 1'b1;
          end
        end
      end
      S_MROW: begin maddr = {fc_r, k_r}; mwe = fc_ok_r; end
      S_MCOL: begin maddr = {k_r, tc_r}; mwe = tc_ok_r; end
      S_MRET: begin maddr = {tc_r, sc_r}; mwe = tc_ok_r && sc_ok_r; end
      S_MIN: begin maddr = line_addr; mre = 1'b1; end
      S_SUB: begin maddr = line_addr; mre = 1'b1; end
      S_SUBW: begin
        maddr = line_addr;
        mwe = !rdata_r[16];
        mwdata = rdata_r - least_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    if (mre) rdata_r <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cities_r <= 5'd16;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_CITIES)
        cities_r <= cfg_pwdata[4:0];
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            fc_r <= in_from_city;
            tc_r <= in_to_city;
            sc_r <= in_start_city;
            fc_ok_r <= {1'b0, in_from_city} < n;
            tc_ok_r <= {1'b0, in_to_city} < n;
            sc_ok_r <= {1'b0, in_start_city} < n;
            k_r <= '0;
            line_r <= '0;
            by_col_r <= 1'b0;
            total_r <= '0;
            least_r <= {1'b1, 16'd0};
            if (in_mode == MODE_READ) begin
              state_r <= S_READ;
            end else if (in_mode == MODE_REDUCE) begin
              if (in_branch) begin
                state_r <= S_BRREAD;
              end else begin
                ov_r <= '0;
                oinf_r <= 1'b0;
                state_r <= S_MIN;
              end
            end
          end
        end
        S_READ: begin
          ov_r <= rdata_r[16] ? 16'd0 : rdata_r[15:0];
          oinf_r <= rdata_r[16];
          out_reduction_total <= '0;
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_BRREAD: begin
          if (!rdata_r[16] && fc_ok_r && tc_ok_r) begin
            ov_r <= rdata_r[15:0];
            oinf_r <= 1'b0;
          end else begin
            ov_r <= '0;
            oinf_r <= 1'b1;
          end
          state_r <= (n == '0) ? S_MIN : S_MROW;
        end
        S_MROW: begin
          if (last_k) begin k_r <= '0; state_r <= S_MCOL; end
          else k_r <= k_nxt_i;
        end
        S_MCOL: begin
          if (last_k) begin k_r <= '0; state_r <= S_MRET; end
          else k_r <= k_nxt_i;
        end
        S_MRET: state_r <= S_MIN;
        S_MIN: begin
          if (n == '0) begin
            state_r <= S_IDLE;
            ovalid_r <= 1'b1;
            out_reduction_total <= '0;
          end else begin
            if (k_r != '0 && !rdata_r[16] && rdata_r < least_r) least_r <= rdata_r;
            k_r <= k_nxt_i;
            if (last_k) state_r <= S_MINLAST;
          end
        end
        S_MINLAST: begin
          logic [ENTRY_W-1:0] lm;
          lm = (!rdata_r[16] && rdata_r < least_r) ? rdata_r : least_r;
          k_r <= '0;
          least_r <= lm;
          if (lm == '0 || lm[16]) state_r <= S_DONE;
          else begin
            state_r <= S_SUB;
          end
        end
        S_SUB: state_r <= S_SUBW;
        S_SUBW: begin
          if (last_k) begin
            k_r <= '0;
            state_r <= S_DONE;
          end else begin
            k_r <= k_nxt_i;
            state_r <= S_SUB;
          end
        end
        S_DONE: begin
          if (!least_r[16] && least_r != '0)
            total_r <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
          least_r <= {1'b1, 16'd0};
          k_r <= '0;
          if (last_line) begin
            line_r <= '0;
            by_col_r <= 1'b1;
            if (by_col_r) begin
              state_r <= S_IDLE;
              ovalid_r <= 1'b1;
              out_reduction_total <= (!least_r[16] && least_r != '0)
                ? (sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0]) : total_r;
            end else begin
              state_r <= S_MIN;
            end
          end else begin
            line_r <= line_r + 1'b1;
            state_r <= S_MIN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_value_out = ov_r;
  assign out_value_is_inf = oinf_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reduction_total))
    else $error("result lost");
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_is_inf |-> out_value_out == 16'd0)
    else $error("infinite value nonzero");
endmodule

[bench/tb_cost_matrix_row_column_reduction.sv]
`timescale 1ns / 1ps
module tb_cost_matrix_row_column_reduction;
  import cmrr_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] val;
    logic        einf;
    logic        br;
    logic [3:0]  fc;
    logic [3:0]  tc;
    logic [3:0]  sc;
    bit          hold;
  } command_t;

  typedef struct {
    logic [15:0] value;
    logic        is_inf;
    logic [20:0] total;
  } answer_t;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_NONE;
  logic [3:0]  in_row = '0;
  logic [3:0]  in_col = '0;
  logic [15:0] in_entry_value = '0;
  logic        in_entry_inf = 1'b0;
  logic        in_branch = 1'b0;
  logic [3:0]  in_from_city = '0;
  logic [3:0]  in_to_city = '0;
  logic [3:0]  in_start_city = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_value_out;
  logic        out_value_is_inf;
  logic [20:0] out_reduction_total;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  command_t pending_cmds[$];
  answer_t  awaited_answers[$];
  logic [16:0] cost_copy[256];
  logic [4:0]  cities_copy = 5'd16;
  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_sizes = 1;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  cost_matrix_row_column_reduction dut (.*);

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    n_errors++;
  endtask

  task automatic reduce_line(input int line, input bit by_row, input int n,
                             inout int total);
    int k;
    int idx;
    int least;
    least = 32'h10000;
    for (k = 0; k < n; k++) begin
      idx = by_row ? line * 16 + k : k * 16 + line;
      if (!cost_copy[idx][16] && cost_copy[idx] < least) least = cost_copy[idx];
    end
    if (least == 0 || least == 32'h10000) return;
    total += least;
    if (total > TOTAL_MAX) total = TOTAL_MAX;
    for (k = 0; k < n; k++) begin
      idx = by_row ? line * 16 + k : k * 16 + line;
      if (!cost_copy[idx][16]) cost_copy[idx] = 17'(cost_copy[idx] - least);
    end
  endtask

  task automatic apply_command(input command_t c);
    int n;
    int k;
    int total;
    logic [16:0] e;
    answer_t a;
    n = (cities_copy > 16) ? 16 : cities_copy;
    a.value = '0;
    a.is_inf = 1'b0;
    a.total = '0;
    case (c.mode)
      MODE_WRITE: begin
        cost_copy[c.row * 16 + c.col] = c.einf ? 17'h10000 : {1'b0, c.val};
      end
      MODE_READ: begin
        e = cost_copy[c.row * 16 + c.col];
        a.is_inf = e[16];
        a.value = e[16] ? 16'd0 : e[15:0];
        awaited_answers = {awaited_answers, a};
      end
      MODE_REDUCE: begin
        if (c.br) begin
          e = 17'h10000;
          if (c.fc < n && c.tc < n) e = cost_copy[c.fc * 16 + c.tc];
          a.is_inf = e[16];
          a.value = e[16] ? 16'd0 : e[15:0];
          for (k = 0; k < n; k++) begin
            if (c.fc < n) cost_copy[c.fc * 16 + k] = 17'h10000;
            if (c.tc < n) cost_copy[k * 16 + c.tc] = 17'h10000;
          end
          if (c.tc < n && c.sc < n) cost_copy[c.tc * 16 + c.sc] = 17'h10000;
        end
        total = 0;
        for (k = 0; k < n; k++) reduce_line(k, 1'b1, n, total);
        for (k = 0; k < n; k++) reduce_line(k, 1'b0, n, total);
        a.total = total[20:0];
        awaited_answers = {awaited_answers, a};
      end
      default: begin
      end
    endcase
  endtask

  // Driver: presents queued commands and predicts each accepted transfer.
  always @(posedge clk) begin
    command_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.mode = in_mode;
        c.row = in_row;
        c.col = in_col;
        c.val = in_entry_value;
        c.einf = in_entry_inf;
        c.br = in_branch;
        c.fc = in_from_city;
        c.tc = in_to_city;
        c.sc = in_start_city;
        apply_command(c);
        n_taken++;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          in_gap <= $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold && awaited_answers.size() > 0)) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_mode <= c.mode;
          in_row <= c.row;
          in_col <= c.col;
          in_entry_value <= c.val;
          in_entry_inf <= c.einf;
          in_branch <= c.br;
          in_from_city <= c.fc;
          in_to_city <= c.tc;
          in_start_city <= c.sc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          a = awaited_answers.pop_front();
          n_checked++;
          if (out_value_out !== a.value)
            report_mismatch("value_out", out_value_out, a.value);
          if (out_value_is_inf !== a.is_inf)
            report_mismatch("value_is_inf", out_value_is_inf, a.is_inf);
          if (out_reduction_total !== a.total)
            report_mismatch("reduction_total", out_reduction_total, a.total);
        end
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic command_t make_cmd(input logic [1:0] mode, input int r, input int c,
                                        input int v, input bit inf, input bit br,
                                        input int fc, input int tc, input int sc);
    command_t x;
    x.mode = mode;
    x.row = 4'(r);
    x.col = 4'(c);
    x.val = 16'(v);
    x.einf = inf;
    x.br = br;
    x.fc = 4'(fc);
    x.tc = 4'(tc);
    x.sc = 4'(sc);
    x.hold = 1'b0;
    return x;
  endfunction

  function automatic command_t random_cmd();
    command_t x;
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 16'hFFFF;
      2: v = $urandom_range(1, 20);
      default: v = $urandom_range(0, 16'hFFFF);
    endcase
    x = make_cmd(MODE_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), v,
                 $urandom_range(0, 5) == 0, $urandom_range(0, 1) == 1,
                 $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
    if (pick >= 95) x.mode = MODE_NONE;
    else if (pick >= 78) x.mode = MODE_READ;
    else if (pick >= 62) begin
      x.mode = MODE_REDUCE;
      x.br = $urandom_range(0, 3) != 0;
    end
    return x;
  endfunction

  task automatic queue_cmd(input command_t c);
    pending_cmds = {pending_cmds, c};
    n_queued++;
  endtask

  task automatic settle();
    while (n_taken < n_queued || awaited_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_cities(input int v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= REG_CITIES;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cities_copy = 5'(v);
    n_sizes++;
  endtask

  initial begin
    int sizes[7] = '{2, 31, 5, 1, 0, 16, 9};
    int i;
    int p;
    command_t c;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < 256; i++)
      queue_cmd(make_cmd(MODE_WRITE, i / 16, i % 16, $urandom_range(0, 16'hFFFF),
                         $urandom_range(0, 7) == 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_WRITE, 15, 15, 16'hFFFF, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_WRITE, 3, 7, 16'hFFFE, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_WRITE, 7, 3, 16'hFFFF, 1, 1, 15, 15, 15));
    queue_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_READ, 15, 15, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_READ, 3, 7, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_READ, 7, 3, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_NONE, 15, 15, 16'hFFFF, 1, 1, 15, 15, 15));
    queue_cmd(make_cmd(MODE_REDUCE, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_REDUCE, 0, 0, 0, 0, 1, 0, 15, 0));
    queue_cmd(make_cmd(MODE_REDUCE, 0, 0, 0, 0, 1, 15, 3, 3));
    queue_cmd(make_cmd(MODE_READ, 15, 3, 0, 0, 0, 0, 0, 0));
    for (p = 0; p <= 7; p++) begin
      if (p > 0) begin
        settle();
        set_cities(sizes[p - 1]);
        if (p == 7) quiet = 1'b1;
        queue_cmd(make_cmd(MODE_REDUCE, 0, 0, 0, 0, 1, 1, 0, 1));
        queue_cmd(make_cmd(MODE_REDUCE, 0, 0, 0, 0, 1, 15, 14, 13));
      end
      for (i = 0; i < 65; i++) begin
        c = random_cmd();
        c.hold = (i % 40 == 20);
        queue_cmd(c);
      end
    end
    settle();
    $display("Checked %0d results from %0d commands across %0d matrix sizes.",
             n_checked, n_queued, n_sizes);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
